// ----- src/dbts_pkg.sv -----
// Shared types and constants of the detection box temporal smoother.
`timescale 1ns / 1ps
`default_nettype none
package dbts_pkg;

    localparam int COORD_W     = 16;
    localparam int CLASS_W     = 8;
    localparam int ENTRY_W     = 5 * COORD_W + CLASS_W;
    localparam int SUM_W       = COORD_W + 1;
    localparam int SQ_W        = 2 * SUM_W;
    localparam int DIST_W      = SQ_W + 1;
    localparam int ALPHA_W     = 9;
    localparam int GATE_W      = 12;
    localparam int HOLD_W      = 5;
    localparam int TAG_W       = 3;
    localparam int NUM_FIELDS  = 5;
    localparam int MAX_BOXES_DEF = 16;
    localparam int MAX_RESULTS = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = 9'd90;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
    localparam logic [GATE_W-1:0]  GATE_RST  = 12'd120;
    localparam logic [HOLD_W-1:0]  HOLD_RST  = 5'd3;
    localparam logic [HOLD_W-1:0]  MISSED_MAX = 5'd31;

    typedef enum logic [1:0] {
        REG_ALPHA = 2'd0,
        REG_GATE  = 2'd1,
        REG_HOLD  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SUM_W-1:0]   cx;
        logic [SUM_W-1:0]   cy;
        logic [CLASS_W-1:0] cls;
    } dbts_query_t;

endpackage
`default_nettype wire

// ----- src/dbts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- src/dbts_match.sv -----
// Nearest same-class candidate search over entries streamed from the table.
`timescale 1ns / 1ps
`default_nettype none
module dbts_match
    import dbts_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF,
    parameter int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 clear,
    input  wire logic                 cand_valid,
    input  wire logic [IW-1:0]        cand_idx,
    input  wire logic [ENTRY_W-1:0]   cand_data,
    input  wire dbts_query_t          query,
    input  wire logic [MAX_BOXES-1:0] taken,
    input  wire logic [SQ_W-1:0]      gate_sq,
    output logic                      busy,
    output logic                      found,
    output logic [IW-1:0]             best_idx,
    output logic [ENTRY_W-1:0]        best_data
);

    logic [SUM_W-1:0]   px, py, dx, dy;
    logic               elig;
    logic               a_v_reg, a_elig_reg, b_v_reg, b_elig_reg;
    logic [IW-1:0]      a_idx_reg, b_idx_reg;
    logic [ENTRY_W-1:0] a_data_reg, b_data_reg;
    logic [SUM_W-1:0]   a_dx_reg, a_dy_reg;
    logic [SQ_W-1:0]    b_sqx_reg, b_sqy_reg;
    logic [DIST_W-1:0]  cand_dist, best_reg;

    assign px = SUM_W'(cand_data[15:0]) + SUM_W'(cand_data[47:32]);
    assign py = SUM_W'(cand_data[31:16]) + SUM_W'(cand_data[63:48]);
    assign dx = (px > query.cx) ? px - query.cx : query.cx - px;
    assign dy = (py > query.cy) ? py - query.cy : query.cy - py;
    assign elig = (cand_data[ENTRY_W-1 -: CLASS_W] == query.cls) && !taken[cand_idx];
    assign cand_dist = DIST_W'(b_sqx_reg) + DIST_W'(b_sqy_reg);
    assign busy = a_v_reg | b_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            found   <= 1'b0;
        end
        else
        begin
            a_v_reg <= cand_valid;
            b_v_reg <= a_v_reg;
            if (clear)
            begin
                found <= 1'b0;
            end
            else if (b_v_reg && b_elig_reg && cand_dist < best_reg)
            begin
                found <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_elig_reg <= elig;
        a_idx_reg  <= cand_idx;
        a_data_reg <= cand_data;
        a_dx_reg   <= dx;
        a_dy_reg   <= dy;
        b_elig_reg <= a_elig_reg;
        b_idx_reg  <= a_idx_reg;
        b_data_reg <= a_data_reg;
        b_sqx_reg  <= a_dx_reg * a_dx_reg;
        b_sqy_reg  <= a_dy_reg * a_dy_reg;
        if (clear)
        begin
            best_reg <= DIST_W'(gate_sq);
        end
        else if (b_v_reg && b_elig_reg && cand_dist < best_reg)
        begin
            best_reg  <= cand_dist;
            best_idx  <= b_idx_reg;
            best_data <= b_data_reg;
        end
    end

endmodule
`default_nettype wire

// ----- src/dbts_blend.sv -----
// Exponential blend of one field: (old*(256-a) + cur*a + 128) >> 8.
`timescale 1ns / 1ps
`default_nettype none
module dbts_blend
    import dbts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [TAG_W-1:0]   in_tag,
    input  wire logic [COORD_W-1:0] old_value,
    input  wire logic [COORD_W-1:0] cur_value,
    input  wire logic [ALPHA_W-1:0] alpha,
    output logic                    out_valid,
    output logic [TAG_W-1:0]        out_tag,
    output logic [COORD_W-1:0]      out_value
);

    logic signed [COORD_W:0]   diff;
    logic signed [COORD_W+10:0] prod, total;

    assign diff  = $signed({1'b0, cur_value}) - $signed({1'b0, old_value});
    assign prod  = diff * $signed({1'b0, alpha});
    assign total = $signed({3'b000, old_value, 8'h00}) + prod + 27'sd128;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_tag   <= in_tag;
        out_value <= total[23:8];
    end

endmodule
`default_nettype wire

// ----- src/detection_box_temporal_smoother.sv -----
// Top level of the detection box temporal smoother: sequencer, tables and ports.
//
// Input words (s_*) carry one detection box, or with s_tuser high a marker for a
// frame without detections; s_tlast flags the last box of a frame. Each box gives
// one output word (m_*); an empty-frame marker gives the stored boxes of the last
// frame again (up to 16) while the empty-frame count is within hold_frames, else
// a single word with box_valid low. Both tables sit in one RAM as two banks that
// swap at frame end.
// A box reads each stored box of the previous frame in turn through the single
// RAM read port, lets the read and distance pipeline drain, emits its word and
// goes back to idle. A match adds a pass of all five fields through the shared
// blend unit; an empty previous table skips the reads. A replayed box is read
// and then emitted.
// One word is worked on at a time; the next is taken as soon as the result sits
// in the output register, which holds while m_tready is low.
// Reset empties both tables and loads the register defaults (alpha 90, gate 120,
// hold 3). Configuration goes through the APB port at 0x0, 0x4 and 0x8.
`timescale 1ns / 1ps
`default_nettype none
module detection_box_temporal_smoother
    import dbts_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // left, top, right, bottom, score, class
    input  wire logic [87:0] s_tdata,
    // frame_empty
    input  wire logic [0:0]  s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // left, top, right, bottom, score, class
    output logic [87:0]      m_tdata,
    // box_valid, matched, overflow
    output logic [2:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int AW = IW + 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEARCH, ST_BLEND, ST_BLEND_WAIT, ST_FINISH, ST_RP_READ, ST_RP_EMIT
    } state_t;

    state_t               state_reg;
    logic [ALPHA_W-1:0]   alpha_reg;
    logic [GATE_W-1:0]    gate_reg;
    logic [HOLD_W-1:0]    hold_reg;
    logic [SQ_W-1:0]      gate_sq_reg;
    logic [ALPHA_W-1:0]   alpha_eff;
    logic [SUM_W-1:0]     gate_x32;
    logic                 cfg_wr;

    logic                 bank_reg;
    logic [CW-1:0]        prior_count_reg, fresh_count_reg, k_reg, lim_reg;
    logic [MAX_BOXES-1:0] taken_reg;
    logic [HOLD_W-1:0]    missed_reg, missed_inc;
    logic [CW-1:0]        replay_n;

    logic [COORD_W-1:0]   res_reg [NUM_FIELDS];
    logic [CLASS_W-1:0]   cls_reg;
    logic                 valid_reg, matched_reg, ovf_reg, last_reg, store_reg, swap_reg;
    logic [TAG_W-1:0]     f_reg;
    logic                 rd_pend_reg;
    logic [IW-1:0]        rd_idx_reg;
    logic                 out_free;
    logic                 emit_word;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;

    dbts_query_t          query;
    logic                 m_clear, m_busy, m_found;
    logic [IW-1:0]        m_best_idx;
    logic [ENTRY_W-1:0]   m_best_data;
    logic                 bl_valid;
    logic [TAG_W-1:0]     bl_tag;
    logic [COORD_W-1:0]   bl_value;
    logic                 accept;

    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign gate_x32  = {gate_reg, 5'b00000};
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid || m_tready;
    assign emit_word = out_free && (state_reg == ST_FINISH || state_reg == ST_RP_EMIT);
    assign missed_inc = (missed_reg < MISSED_MAX) ? missed_reg + 1'b1 : missed_reg;
    assign replay_n  = (missed_inc > hold_reg) ? '0 :
                       (32'(prior_count_reg) > MAX_RESULTS) ? CW'(MAX_RESULTS) :
                       prior_count_reg;
    assign m_clear   = accept;

    always_comb
    begin
        prdata = '0;
        case (cfg_reg_t'(paddr[3:2]))
            REG_ALPHA: prdata = 32'(alpha_reg);
            REG_GATE:  prdata = 32'(gate_reg);
            REG_HOLD:  prdata = 32'(hold_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RST;
            gate_reg  <= GATE_RST;
            hold_reg  <= HOLD_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_reg_t'(paddr[3:2]))
                REG_ALPHA: alpha_reg <= pwdata[ALPHA_W-1:0];
                REG_GATE:  gate_reg  <= pwdata[GATE_W-1:0];
                REG_HOLD:  hold_reg  <= pwdata[HOLD_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        gate_sq_reg <= gate_x32 * gate_x32;
    end

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = {bank_reg, k_reg[IW-1:0]};
        ram_we    = 1'b0;
        ram_waddr = {~bank_reg, fresh_count_reg[IW-1:0]};
        ram_wdata = {cls_reg, res_reg[4], res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
        case (state_reg)
            ST_SEARCH:  ram_re = (k_reg < lim_reg);
            ST_RP_READ: ram_re = 1'b1;
            ST_FINISH:  ram_we = out_free && store_reg;
            default:    ram_re = 1'b0;
        endcase
    end

    assign query.cx  = SUM_W'(res_reg[0]) + SUM_W'(res_reg[2]);
    assign query.cy  = SUM_W'(res_reg[1]) + SUM_W'(res_reg[3]);
    assign query.cls = cls_reg;

    dbts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (2 ** AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dbts_match #(
        .MAX_BOXES (MAX_BOXES),
        .IW        (IW)
    ) u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (m_clear),
        .cand_valid (rd_pend_reg),
        .cand_idx   (rd_idx_reg),
        .cand_data  (ram_rdata),
        .query      (query),
        .taken      (taken_reg),
        .gate_sq    (gate_sq_reg),
        .busy       (m_busy),
        .found      (m_found),
        .best_idx   (m_best_idx),
        .best_data  (m_best_data)
    );

    dbts_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (state_reg == ST_BLEND),
        .in_tag    (f_reg),
        .old_value (m_best_data[f_reg*COORD_W +: COORD_W]),
        .cur_value (res_reg[f_reg]),
        .alpha     (alpha_eff),
        .out_valid (bl_valid),
        .out_tag   (bl_tag),
        .out_value (bl_value)
    );

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= k_reg[IW-1:0];
        if (accept)
        begin
            if (s_tuser[0])
            begin
                for (int i = 0; i < NUM_FIELDS; i++)
                begin
                    res_reg[i] <= '0;
                end
                cls_reg <= '0;
            end
            else
            begin
                for (int i = 0; i < NUM_FIELDS; i++)
                begin
                    res_reg[i] <= s_tdata[i*COORD_W +: COORD_W];
                end
                cls_reg <= s_tdata[87:80];
            end
        end
        else if (bl_valid)
        begin
            res_reg[bl_tag] <= bl_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            bank_reg        <= 1'b0;
            prior_count_reg <= '0;
            fresh_count_reg <= '0;
            taken_reg       <= '0;
            missed_reg      <= '0;
            k_reg           <= '0;
            lim_reg         <= '0;
            f_reg           <= '0;
            rd_pend_reg     <= 1'b0;
            valid_reg       <= 1'b0;
            matched_reg     <= 1'b0;
            ovf_reg         <= 1'b0;
            last_reg        <= 1'b0;
            store_reg       <= 1'b0;
            swap_reg        <= 1'b0;
            m_tvalid        <= 1'b0;
            m_tdata         <= '0;
            m_tuser         <= '0;
            m_tlast         <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= ram_re && (state_reg == ST_SEARCH);
            if (m_tvalid && m_tready && !emit_word)
            begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        k_reg       <= '0;
                        matched_reg <= 1'b0;
                        if (s_tuser[0])
                        begin
                            fresh_count_reg <= '0;
                            taken_reg       <= '0;
                            missed_reg      <= missed_inc;
                            if (missed_inc > hold_reg)
                            begin
                                prior_count_reg <= '0;
                            end
                            lim_reg   <= replay_n;
                            valid_reg <= 1'b0;
                            ovf_reg   <= 1'b0;
                            last_reg  <= 1'b1;
                            store_reg <= 1'b0;
                            swap_reg  <= 1'b0;
                            state_reg <= (replay_n == '0) ? ST_FINISH : ST_RP_READ;
                        end
                        else
                        begin
                            missed_reg <= '0;
                            valid_reg  <= 1'b1;
                            last_reg   <= s_tlast;
                            swap_reg   <= s_tlast;
                            lim_reg    <= prior_count_reg;
                            if (32'(fresh_count_reg) >= MAX_BOXES)
                            begin
                                ovf_reg   <= 1'b1;
                                store_reg <= 1'b0;
                                state_reg <= ST_FINISH;
                            end
                            else
                            begin
                                ovf_reg   <= 1'b0;
                                store_reg <= 1'b1;
                                state_reg <= ST_SEARCH;
                            end
                        end
                    end
                end
                ST_SEARCH:
                begin
                    if (ram_re)
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                    else if (!rd_pend_reg && !m_busy)
                    begin
                        matched_reg <= m_found;
                        f_reg       <= '0;
                        state_reg   <= m_found ? ST_BLEND : ST_FINISH;
                    end
                end
                ST_BLEND:
                begin
                    f_reg <= f_reg + 1'b1;
                    if (f_reg == TAG_W'(NUM_FIELDS - 1))
                    begin
                        state_reg <= ST_BLEND_WAIT;
                    end
                end
                ST_BLEND_WAIT:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        m_tvalid <= 1'b1;
                        m_tdata  <= ram_wdata;
                        m_tuser  <= {ovf_reg, matched_reg, valid_reg};
                        m_tlast  <= last_reg;
                        if (swap_reg)
                        begin
                            bank_reg        <= ~bank_reg;
                            prior_count_reg <= fresh_count_reg + CW'(store_reg);
                            fresh_count_reg <= '0;
                            taken_reg       <= '0;
                        end
                        else
                        begin
                            if (matched_reg)
                            begin
                                taken_reg[m_best_idx] <= 1'b1;
                            end
                            if (store_reg)
                            begin
                                fresh_count_reg <= fresh_count_reg + 1'b1;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RP_READ:
                begin
                    state_reg <= ST_RP_EMIT;
                end
                ST_RP_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid <= 1'b1;
                        m_tdata  <= ram_rdata;
                        m_tuser  <= 3'b001;
                        m_tlast  <= (k_reg + 1'b1 == lim_reg);
                        k_reg    <= k_reg + 1'b1;
                        state_reg <= (k_reg + 1'b1 == lim_reg) ? ST_IDLE : ST_RP_READ;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while one is in work");
    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fresh_count_reg) <= MAX_BOXES)
        else $error("fresh table count beyond capacity");
    a_prior_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(prior_count_reg) <= MAX_BOXES)
        else $error("prior table count beyond capacity");
    a_no_store_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ovf_reg && valid_reg)
        else $error("table write for an overflow or empty result");
`endif

endmodule
`default_nettype wire
